/* design/square_wave_sound_channel_unit_macros.svh */
// assertion macros used by the square wave channel rtl
`ifndef SQUARE_WAVE_SOUND_CHANNEL_UNIT_MACROS_SVH
`define SQUARE_WAVE_SOUND_CHANNEL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SQC_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("sqc assertion failed");
`define SQC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("sqc assertion failed");
`else
`define SQC_ASSERT(label, expr)
`define SQC_ASSERT_NEXT(label, pre, post)
`endif
`endif

/* design/sqc_pkg.sv */
// types, codes and helper functions for the square wave channel
package sqc_pkg;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_LEN_CLK   = 3'd1;
    localparam logic [2:0] OP_ENV_CLK   = 3'd2;
    localparam logic [2:0] OP_READ      = 3'd3;
    localparam logic [2:0] OP_WRITE     = 3'd4;

    localparam logic [15:0] ADDR_DUTY_LEN = 16'hFF16;
    localparam logic [15:0] ADDR_ENVELOPE = 16'hFF17;
    localparam logic [15:0] ADDR_FREQ_LO  = 16'hFF18;
    localparam logic [15:0] ADDR_FREQ_HI  = 16'hFF19;

    localparam logic [7:0] READ_IDLE    = 8'hFF;
    localparam logic [7:0] READ_LOW_SET = 8'h3F;
    localparam logic [7:0] READ_TOP_SET = 8'h80;
    localparam logic [6:0] LENGTH_FULL  = 7'd64;
    localparam logic [6:0] LENGTH_ODD   = 7'd63;
    localparam logic [3:0] VOLUME_MAX   = 4'd15;
    localparam logic [12:0] DIVIDER_MAX = 13'd4096;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        sequencer_odd;
    } t_in_item;

    typedef struct packed {
        logic [3:0] sample;
        logic [7:0] read_data;
    } t_out_item;

    // 2 * (2048 - freq), one bit wider than the frequency field plus one
    function automatic logic [12:0] divider_reload(input logic [10:0] freq);
        logic [11:0] period;
        period = 12'd2048 - {1'b0, freq};
        return {period, 1'b0};
    endfunction

    function automatic logic duty_pattern(input logic [1:0] sel, input logic [2:0] step);
        logic bit_out;
        case (sel)
            2'd0: bit_out = (step == 3'd6);
            2'd1: bit_out = (step >= 3'd6);
            2'd2: bit_out = (step >= 3'd4);
            default: bit_out = (step <= 3'd5);
        endcase
        return bit_out;
    endfunction

endpackage

/* design/sqc_in_reg.sv */
// input holding register for one request
module sqc_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sqc_pkg::t_in_item  i_item,
    input  logic               i_drain,
    output logic               o_fire,
    output sqc_pkg::t_in_item  o_item
);

    logic              r_valid;
    sqc_pkg::t_in_item r_item;

    assign o_fire  = r_valid && i_drain;
    assign o_ready = !r_valid || o_fire;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* design/sqc_core.sv */
// channel state registers and the per-request update logic
`include "square_wave_sound_channel_unit_macros.svh"

module sqc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  sqc_pkg::t_in_item  i_item,
    output sqc_pkg::t_out_item o_result
);

    logic        r_channel_on,    n_channel_on;
    logic [1:0]  r_duty_select,   n_duty_select;
    logic [6:0]  r_length_left,   n_length_left;
    logic [3:0]  r_env_start,     n_env_start;
    logic        r_env_rising,    n_env_rising;
    logic [2:0]  r_env_rate,      n_env_rate;
    logic [10:0] r_freq,          n_freq;
    logic        r_length_active, n_length_active;
    logic [3:0]  r_level_out,     n_level_out;
    logic        r_duty_bit,      n_duty_bit;
    logic [2:0]  r_duty_step,     n_duty_step;
    logic [12:0] r_divider,       n_divider;
    logic [2:0]  r_env_countdown, n_env_countdown;
    logic [3:0]  r_cur_volume,    n_cur_volume;
    logic [7:0]  read_value;
    logic        dac_now;
    logic        dac_new;

    assign dac_now = (r_env_start != 4'd0) || r_env_rising;
    assign dac_new = (i_item.write_data[7:4] != 4'd0) || i_item.write_data[3];

    always_comb begin
        n_channel_on    = r_channel_on;
        n_duty_select   = r_duty_select;
        n_length_left   = r_length_left;
        n_env_start     = r_env_start;
        n_env_rising    = r_env_rising;
        n_env_rate      = r_env_rate;
        n_freq          = r_freq;
        n_length_active = r_length_active;
        n_level_out     = r_level_out;
        n_duty_bit      = r_duty_bit;
        n_duty_step     = r_duty_step;
        n_divider       = r_divider;
        n_env_countdown = r_env_countdown;
        n_cur_volume    = r_cur_volume;
        read_value      = sqc_pkg::READ_IDLE;

        case (i_item.opcode)
            sqc_pkg::OP_TICK: begin
                if (r_divider != 13'd0) begin
                    n_divider = r_divider - 13'd1;
                    if (n_divider == 13'd0) begin
                        n_divider   = sqc_pkg::divider_reload(r_freq);
                        n_duty_step = r_duty_step + 3'd1;
                        n_duty_bit  = sqc_pkg::duty_pattern(r_duty_select, n_duty_step);
                    end
                end
                n_level_out = (n_duty_bit && r_channel_on) ? r_cur_volume : 4'd0;
            end
            sqc_pkg::OP_LEN_CLK: begin
                if (r_length_active && r_length_left != 7'd0) begin
                    n_length_left = r_length_left - 7'd1;
                    if (n_length_left == 7'd0) begin
                        n_channel_on = 1'b0;
                    end
                end
            end
            sqc_pkg::OP_ENV_CLK: begin
                if (r_channel_on && r_env_rate != 3'd0) begin
                    n_env_countdown = r_env_countdown - 3'd1;
                    if (n_env_countdown == 3'd0) begin
                        n_env_countdown = r_env_rate;
                        if (!r_env_rising && r_cur_volume != 4'd0) begin
                            n_cur_volume = r_cur_volume - 4'd1;
                        end
                        if (r_env_rising && r_cur_volume != sqc_pkg::VOLUME_MAX) begin
                            n_cur_volume = r_cur_volume + 4'd1;
                        end
                    end
                end
            end
            sqc_pkg::OP_READ: begin
                case (i_item.address)
                    sqc_pkg::ADDR_DUTY_LEN: begin
                        read_value = {r_duty_select, 6'd0} | sqc_pkg::READ_LOW_SET;
                    end
                    sqc_pkg::ADDR_ENVELOPE: begin
                        read_value = {r_env_start, r_env_rising, r_env_rate};
                    end
                    sqc_pkg::ADDR_FREQ_HI: begin
                        read_value = sqc_pkg::READ_TOP_SET | {1'b0, r_length_active, 6'd0}
                                   | sqc_pkg::READ_LOW_SET;
                    end
                    default: begin
                        read_value = sqc_pkg::READ_IDLE;
                    end
                endcase
            end
            sqc_pkg::OP_WRITE: begin
                case (i_item.address)
                    sqc_pkg::ADDR_DUTY_LEN: begin
                        n_duty_select = i_item.write_data[7:6];
                        n_length_left = sqc_pkg::LENGTH_FULL - {1'b0, i_item.write_data[5:0]};
                    end
                    sqc_pkg::ADDR_ENVELOPE: begin
                        n_env_start  = i_item.write_data[7:4];
                        n_env_rising = i_item.write_data[3];
                        n_env_rate   = i_item.write_data[2:0];
                        if (!dac_new) begin
                            n_channel_on = 1'b0;
                        end
                    end
                    sqc_pkg::ADDR_FREQ_LO: begin
                        n_freq = {r_freq[10:8], i_item.write_data};
                    end
                    sqc_pkg::ADDR_FREQ_HI: begin
                        // enabling length on an odd sequencer step clocks it once
                        if (i_item.sequencer_odd && !r_length_active && i_item.write_data[6]
                                && r_length_left != 7'd0) begin
                            n_length_left = r_length_left - 7'd1;
                            if (n_length_left == 7'd0) begin
                                n_channel_on = 1'b0;
                            end
                        end
                        n_length_active = i_item.write_data[6];
                        n_freq          = {i_item.write_data[2:0], r_freq[7:0]};
                        if (i_item.write_data[7]) begin
                            n_channel_on    = dac_now;
                            n_divider       = sqc_pkg::divider_reload(n_freq);
                            n_env_countdown = r_env_rate;
                            n_cur_volume    = r_env_start;
                            if (n_length_left == 7'd0) begin
                                n_length_left = (i_item.sequencer_odd && n_length_active)
                                              ? sqc_pkg::LENGTH_ODD : sqc_pkg::LENGTH_FULL;
                            end
                        end
                    end
                    default: begin
                        n_duty_select = r_duty_select;
                    end
                endcase
            end
            default: begin
                read_value = sqc_pkg::READ_IDLE;
            end
        endcase
    end

    assign o_result.sample    = n_level_out;
    assign o_result.read_data = read_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_on    <= 1'b0;
            r_duty_select   <= 2'd0;
            r_length_left   <= sqc_pkg::LENGTH_FULL;
            r_env_start     <= 4'd0;
            r_env_rising    <= 1'b0;
            r_env_rate      <= 3'd0;
            r_freq          <= 11'd0;
            r_length_active <= 1'b0;
            r_level_out     <= 4'd0;
            r_duty_bit      <= 1'b0;
            r_duty_step     <= 3'd0;
            r_divider       <= 13'd0;
            r_env_countdown <= 3'd0;
            r_cur_volume    <= 4'd0;
        end else if (i_fire) begin
            r_channel_on    <= n_channel_on;
            r_duty_select   <= n_duty_select;
            r_length_left   <= n_length_left;
            r_env_start     <= n_env_start;
            r_env_rising    <= n_env_rising;
            r_env_rate      <= n_env_rate;
            r_freq          <= n_freq;
            r_length_active <= n_length_active;
            r_level_out     <= n_level_out;
            r_duty_bit      <= n_duty_bit;
            r_duty_step     <= n_duty_step;
            r_divider       <= n_divider;
            r_env_countdown <= n_env_countdown;
            r_cur_volume    <= n_cur_volume;
        end
    end

    // the channel can only be running while its dac is powered
    `SQC_ASSERT(a_on_needs_dac, !r_channel_on || dac_now)
    `SQC_ASSERT(a_length_range, r_length_left <= sqc_pkg::LENGTH_FULL)
    `SQC_ASSERT(a_divider_range, r_divider <= sqc_pkg::DIVIDER_MAX)
    `SQC_ASSERT_NEXT(a_hold_when_idle, !i_fire,
        $stable(r_duty_step) && $stable(r_divider) && $stable(r_cur_volume))

endmodule

/* design/sqc_out_reg.sv */
// result register feeding the output channel
module sqc_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  sqc_pkg::t_out_item  i_result,
    input  logic                i_ready,
    output logic                o_valid,
    output sqc_pkg::t_out_item  o_data,
    output logic                o_can_load
);

    logic               r_valid;
    sqc_pkg::t_out_item r_data;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

endmodule

/* design/square_wave_sound_channel_unit.sv */
// top level of the square wave sound channel
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one request per
//   transfer: an audio tick, a length clock, an envelope clock, a bus read or a
//   bus write. Output channel (o_out_valid / i_out_ready / o_out_data) returns
//   exactly one result per request, in order: the sample level after that
//   request and the read byte (0xff unless a read hits a readable register).
// Timing:
//   a request sits in the input register while the channel state and its result
//   are computed, then the result is registered in the output register when the
//   request fires. Throughput is one request per cycle while the output is not
//   stalled, set by the state update between the two registers.
// Reset (i_rst_n low at a clock edge) clears both valid bits and returns the
//   channel to power-on state: off, length counter at 64, everything else zero.
// Stalls: while a result waits for i_out_ready, one more request may be taken
//   into the input register; after that o_in_ready drops until the output
//   drains. Nothing is lost or repeated.
module square_wave_sound_channel_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sqc_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sqc_pkg::t_out_item  o_out_data
);

    logic               can_load;
    logic               fire;
    sqc_pkg::t_in_item  item;
    sqc_pkg::t_out_item result;

    sqc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .i_drain (can_load),
        .o_fire  (fire),
        .o_item  (item)
    );

    sqc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (item),
        .o_result (result)
    );

    sqc_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_result   (result),
        .i_ready    (i_out_ready),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data),
        .o_can_load (can_load)
    );

endmodule
